// ===== design/rgb2yuv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types and constants for the RGB pair to YUV 4:2:2 converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

  localparam int unsigned CompW = 8;

  // byte order codes of the output_order register
  localparam logic ORDER_YUY2 = 1'b0;
  localparam logic ORDER_UYVY = 1'b1;

  typedef logic [CompW-1:0] comp_t;

  // per-pixel result of one lane
  typedef struct packed {
    comp_t              luma;
    logic signed [7:0]  u_term;
    logic signed [7:0]  v_term;
  } lane_res_t;

  // packed 4:2:2 word
  typedef struct packed {
    comp_t byte_three;
    comp_t byte_two;
    comp_t byte_one;
    comp_t byte_zero;
  } yuv_word_t;

endpackage : rgb2yuv_pkg
`default_nettype wire

// ===== design/rgb2yuv_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2yuv_lane
// One pixel lane: luma and the two floored chroma terms of one RGB pixel.
// ----------------------------------------------------------------------------
module rgb2yuv_lane (
  input  wire  rgb2yuv_pkg::comp_t     red,
  input  wire  rgb2yuv_pkg::comp_t     green,
  input  wire  rgb2yuv_pkg::comp_t     blue,
  output rgb2yuv_pkg::lane_res_t       res
);
  import rgb2yuv_pkg::*;

  logic        [16:0] r_u, g_u, b_u;
  logic signed [16:0] r_s, g_s, b_s;
  logic        [16:0] luma_sum;
  logic signed [16:0] u_sum;
  logic signed [16:0] v_sum;

  assign r_u = {9'd0, red};
  assign g_u = {9'd0, green};
  assign b_u = {9'd0, blue};
  assign r_s = signed'(r_u);
  assign g_s = signed'(g_u);
  assign b_s = signed'(b_u);

  // luma sum peaks at 56228, so it never leaves 16 bits
  assign luma_sum = 17'd66 * r_u + 17'd129 * g_u + 17'd25 * b_u + 17'd128;

  // chroma sums stay within +/-28688; bits 15:8 are the floored quotient
  assign u_sum = -(17'sd38 * r_s) - 17'sd74 * g_s + 17'sd112 * b_s + 17'sd128;
  assign v_sum = 17'sd112 * r_s - 17'sd94 * g_s - 17'sd18 * b_s + 17'sd128;

  assign res.luma   = luma_sum[15:8] + 8'd16;
  assign res.u_term = u_sum[15:8];
  assign res.v_term = v_sum[15:8];

endmodule : rgb2yuv_lane
`default_nettype wire

// ===== design/rgb2yuv_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb2yuv_merge
// Merge two lanes: average the chroma, clamp the chroma bytes, pack in the order set.
// ----------------------------------------------------------------------------
module rgb2yuv_merge (
  input  wire  rgb2yuv_pkg::lane_res_t lane_a,
  input  wire  rgb2yuv_pkg::lane_res_t lane_b,
  input  wire                          order,
  output rgb2yuv_pkg::yuv_word_t       word
);
  import rgb2yuv_pkg::*;

  function automatic comp_t chroma_avg(input logic signed [7:0] ta,
                                       input logic signed [7:0] tb);
    logic signed [8:0] sum;
    logic signed [8:0] half;
    logic signed [9:0] biased;
    comp_t             res;
    sum    = {ta[7], ta} + {tb[7], tb};
    // halve with truncation toward zero
    half   = (sum + $signed({8'd0, sum[8]})) >>> 1;
    biased = {half[8], half} + 10'sd128;
    if (biased < 10'sd0) begin
      res = '0;
    end else if (biased > 10'sd255) begin
      res = 8'hFF;
    end else begin
      res = biased[7:0];
    end
    return res;
  endfunction

  comp_t u_byte, v_byte;

  assign u_byte = chroma_avg(lane_a.u_term, lane_b.u_term);
  assign v_byte = chroma_avg(lane_a.v_term, lane_b.v_term);

  always_comb begin
    case (order)
      ORDER_UYVY: begin
        word.byte_zero  = u_byte;
        word.byte_one   = lane_a.luma;
        word.byte_two   = v_byte;
        word.byte_three = lane_b.luma;
      end
      default: begin
        word.byte_zero  = lane_a.luma;
        word.byte_one   = u_byte;
        word.byte_two   = lane_b.luma;
        word.byte_three = v_byte;
      end
    endcase
  end

endmodule : rgb2yuv_merge
`default_nettype wire

// ===== design/rgb_pair_to_yuv422.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_pair_to_yuv422
// Path: an input transfer is registered in the lane register, then in the output register behind out_tvalid.
// Throughput: one pixel pair per clock while out_tready holds; back-pressure stalls the two-stage pipeline.
// Reset (rst_n low, synchronous) empties both stages and selects YUY2 order.
// Two pixel lanes feed a lane register; the merge stage fills the output one.
// ----------------------------------------------------------------------------
module rgb_pair_to_yuv422 (
  input  wire         clk,
  input  wire         rst_n,
  // configuration: bit 0 is output_order
  input  wire         cfg_wr_en,
  input  wire  [0:0]  cfg_wr_data,
  // tdata: red_a, green_a, blue_a, red_b, green_b, blue_b (8 bits each, low up)
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,
  // tdata: byte_zero, byte_one, byte_two, byte_three (8 bits each, low up)
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata
);
  import rgb2yuv_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic order_r, order_nxt;

  assign order_nxt = cfg_wr_en ? cfg_wr_data[0] : order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_YUY2;
    end else begin
      order_r <= order_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage readiness: each stage advances when the one after it can take data
  // --------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s2_rdy, s1_rdy;
  logic in_xfer, s1_move;

  assign s2_rdy    = !out_valid_r || out_tready;
  assign s1_rdy    = !s1_valid_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_xfer   = in_tvalid && s1_rdy;
  assign s1_move   = s1_valid_r && s2_rdy;

  // --------------------------------------------------------------------------
  // Pixel lanes, one per pixel of the pair
  // --------------------------------------------------------------------------
  lane_res_t lane_a, lane_b;
  lane_res_t lane_a_r, lane_b_r;

  rgb2yuv_lane u_lane_a (
    .red   (in_tdata[7:0]),
    .green (in_tdata[15:8]),
    .blue  (in_tdata[23:16]),
    .res   (lane_a)
  );

  rgb2yuv_lane u_lane_b (
    .red   (in_tdata[31:24]),
    .green (in_tdata[39:32]),
    .blue  (in_tdata[47:40]),
    .res   (lane_b)
  );

  assign s1_valid_nxt = in_xfer || (s1_valid_r && !s2_rdy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // hold lane results until the merge stage takes them
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lane_a_r <= lane_a;
      lane_b_r <= lane_b;
    end
  end

  // --------------------------------------------------------------------------
  // Merge stage and output register
  // --------------------------------------------------------------------------
  yuv_word_t merged;
  yuv_word_t out_word_r;

  rgb2yuv_merge u_merge (
    .lane_a (lane_a_r),
    .lane_b (lane_b_r),
    .order  (order_r),
    .word   (merged)
  );

  assign out_valid_nxt = s1_move || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_word_r <= merged;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // a full, stalled lane register must refuse new transfers
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_rdy) |-> !in_tready)
    else $error("input taken while lane register stalled");

  // a drained output with nothing behind it goes idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after transfer");

  // a pending lane result moves into the output register whenever the output stage is free
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_rdy) |=> out_valid_r)
    else $error("lane result lost");

  // luma bytes stay in the studio range (checked in YUY2 order)
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && order_r == ORDER_YUY2) |->
      (out_word_r.byte_zero >= 8'd16 && out_word_r.byte_zero <= 8'd235 &&
       out_word_r.byte_two >= 8'd16 && out_word_r.byte_two <= 8'd235))
    else $error("luma outside studio range");

endmodule : rgb_pair_to_yuv422
`default_nettype wire
